>>> hw/rtl/flow_sequence_gap_monitor_unit_defines.svh
// Assertion macros shared by the monitor's RTL files.
`ifndef FLOW_SEQUENCE_GAP_MONITOR_UNIT_DEFINES_SVH
`define FLOW_SEQUENCE_GAP_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked while reset is released.
`define FSGM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while reset is released.
`define FSGM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/fsgm_pkg.sv
package fsgm_pkg;

	// Widest flow index the table supports (64 flows).
	localparam int unsigned IDX_W_MAX = 6;
	// A scan reports at most this many flows.
	localparam int unsigned MAX_REPORTS = 16;
	// Depth of the job queue between front and back.
	localparam int unsigned QDEPTH = 2;
	localparam logic [31:0] TIMEOUT_RESET = 32'd2000;

	localparam logic [1:0] OP_PACKET = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_SCAN   = 2'd2;

	localparam logic RES_PACKET = 1'b0;
	localparam logic RES_SCAN   = 1'b1;

	typedef enum logic [1:0] {
		JOB_PKT,
		JOB_FULL,
		JOB_TICK,
		JOB_SCAN
	} job_kind_t;

	typedef struct packed {
		job_kind_t              kind;
		logic [IDX_W_MAX-1:0]   idx;
		logic                   fresh;
		logic [31:0]            seq_id;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PKT,
		BK_SCAN,
		BK_DRAIN,
		BK_FLUSH
	} back_state_t;

endpackage

>>> hw/rtl/flow_sequence_gap_monitor_unit.sv
// A packet request goes through the front register, the job queue, the pop with its RAM read,
// the BK_PKT state and the result registers; a full-table report is emitted at the pop.
// A tick completes at the pop; a scan reads each flow RAM entry once, then drains and flushes.
// A two-entry job queue lets the front accept while the back end works; busy rises when full.
// Reset clears the flow table, the tick counter and sets the timeout to 2000; no clearing pass.
// Reports cannot be stalled: each one is on the result ports for exactly one cycle.

module flow_sequence_gap_monitor_unit import fsgm_pkg::*; #(
	parameter int FLOWS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] src_addr,
	input  logic [15:0] src_port,
	input  logic [31:0] seq_id,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic        res_valid,
	output logic        kind,
	output logic [3:0]  flow_index,
	output logic        table_full,
	output logic        discovered,
	output logic        missed,
	output logic [31:0] missed_from,
	output logic [31:0] missed_to,
	output logic        timed_out,
	output logic [31:0] elapsed,
	output logic        last
);

	// The front end registers each request, matches the sender key against the
	// key table in parallel, and turns the request into a job: a packet for a known
	// or newly inserted flow, a rejected packet when the table is full, a tick or a
	// scan. Opcode three is dropped there and never reaches the queue.
	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head_job;

	fsgm_front #(
		.FLOWS (FLOWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.opcode   (opcode),
		.src_addr (src_addr),
		.src_port (src_port),
		.seq_id   (seq_id),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// Jobs are carried out strictly in order, so a tick or scan always sees the
	// table exactly as the earlier requests left it.
	fsgm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head_job)
	);

	// The back end owns the tick counter, the timeout register and the RAM with
	// each flow's last id and arrival tick. It does the read-modify-write for a
	// packet and walks the RAM for a scan, holding one report back so that the
	// final one of the scan can carry the last marker.
	fsgm_back #(
		.FLOWS (FLOWS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.empty       (q_empty),
		.head        (head_job),
		.pop         (pop),
		.res_valid   (res_valid),
		.kind        (kind),
		.flow_index  (flow_index),
		.table_full  (table_full),
		.discovered  (discovered),
		.missed      (missed),
		.missed_from (missed_from),
		.missed_to   (missed_to),
		.timed_out   (timed_out),
		.elapsed     (elapsed),
		.last        (last)
	);

endmodule

>>> hw/rtl/fsgm_ram.sv
module fsgm_ram import fsgm_pkg::*; #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                    wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                    rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/fsgm_front.sv
module fsgm_front import fsgm_pkg::*; #(
	parameter int FLOWS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] src_addr,
	input  logic [15:0] src_port,
	input  logic [31:0] seq_id,
	input  logic        q_full,
	output logic        push,
	output job_t        push_job
);

	localparam int IW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
	localparam int CW = IW + 1;

	logic              vld_s1;
	logic [1:0]        op_s1;
	logic [31:0]       addr_s1;
	logic [15:0]       port_s1;
	logic [31:0]       id_s1;

	logic [31:0]       key_addr_q [FLOWS];
	logic [15:0]       key_port_q [FLOWS];
	logic [CW-1:0]     fill_q;

	logic              accept;
	logic              drop;
	logic              s1_done;
	logic              hit;
	logic              full;
	logic              insert;
	logic [FLOWS-1:0]  match;
	logic [IW-1:0]     hit_idx;

	assign accept  = start && !busy;
	assign busy    = vld_s1 && q_full;
	assign s1_done = vld_s1 && (drop || !q_full);
	assign push    = vld_s1 && !q_full && !drop;
	assign hit     = |match;
	assign full    = (fill_q == CW'(FLOWS));
	assign insert  = push && (op_s1 == OP_PACKET) && !hit && !full;

	// Key match against every stored sender; keys are unique so at most one hits.
	always_comb begin
		match   = '0;
		hit_idx = '0;
		for (int i = 0; i < FLOWS; i++) begin
			if ((CW'(i) < fill_q) && (key_addr_q[i] == addr_s1) &&
			    (key_port_q[i] == port_s1)) begin
				match[i] = 1'b1;
				hit_idx  = hit_idx | IW'(i);
			end
		end
	end

	always_comb begin
		drop            = 1'b0;
		push_job.kind   = JOB_TICK;
		push_job.idx    = '0;
		push_job.fresh  = 1'b0;
		push_job.seq_id = id_s1;
		case (op_s1)
			OP_PACKET: begin
				if (hit) begin
					push_job.kind = JOB_PKT;
					push_job.idx  = IDX_W_MAX'(hit_idx);
				end else if (full) begin
					push_job.kind = JOB_FULL;
				end else begin
					push_job.kind  = JOB_PKT;
					push_job.idx   = IDX_W_MAX'(fill_q[IW-1:0]);
					push_job.fresh = 1'b1;
				end
			end
			OP_TICK: push_job.kind = JOB_TICK;
			OP_SCAN: push_job.kind = JOB_SCAN;
			default: drop = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fill_q <= '0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (s1_done) begin
				vld_s1 <= 1'b0;
			end
			if (insert) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= opcode;
			addr_s1 <= src_addr;
			port_s1 <= src_port;
			id_s1   <= seq_id;
		end
		if (insert) begin
			key_addr_q[fill_q[IW-1:0]] <= addr_s1;
			key_port_q[fill_q[IW-1:0]] <= port_s1;
		end
	end

endmodule

>>> hw/rtl/fsgm_queue.sv
`include "flow_sequence_gap_monitor_unit_defines.svh"

module fsgm_queue import fsgm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	job_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW + 1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PW + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	`FSGM_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !full, "job pushed into a full queue")
	`FSGM_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !empty, "job popped from an empty queue")

endmodule

>>> hw/rtl/fsgm_back.sv
`include "flow_sequence_gap_monitor_unit_defines.svh"

module fsgm_back import fsgm_pkg::*; #(
	parameter int FLOWS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        empty,
	input  job_t        head,
	output logic        pop,
	output logic        res_valid,
	output logic        kind,
	output logic [3:0]  flow_index,
	output logic        table_full,
	output logic        discovered,
	output logic        missed,
	output logic [31:0] missed_from,
	output logic [31:0] missed_to,
	output logic        timed_out,
	output logic [31:0] elapsed,
	output logic        last
);

	localparam int IW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
	localparam int XW = IW + 4;
	localparam int FW = $clog2(MAX_REPORTS + 1);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [31:0]       timeout_q;
	logic [31:0]       now_q;
	logic [FLOWS-1:0]  bvalid_q;
	job_t              cur_q;
	logic [IW-1:0]     cnt_q;
	logic              vld_s1;
	logic [IW-1:0]     idx_s1;
	logic              pend_vld_q;
	logic [IW-1:0]     pend_idx_q;
	logic [31:0]       pend_el_q;
	logic [FW-1:0]     found_q;

	logic              res_valid_q;
	logic              kind_q;
	logic [3:0]        flow_index_q;
	logic              table_full_q;
	logic              discovered_q;
	logic              missed_q;
	logic [31:0]       missed_from_q;
	logic [31:0]       missed_to_q;
	logic              timed_out_q;
	logic [31:0]       elapsed_q;
	logic              last_q;

	logic [IW-1:0]     raddr;
	logic              we;
	logic [IW-1:0]     waddr;
	logic [63:0]       wdata;
	logic [63:0]       rdata;

	logic [31:0]       stored_id;
	logic [31:0]       stored_t;
	logic [31:0]       prev_id;
	logic              pk_disc;
	logic [31:0]       eff_id;
	logic              pk_miss;
	logic [31:0]       pk_el;
	logic [31:0]       sc_el;
	logic              sc_hit;

	logic              emit;
	logic              e_kind;
	logic [IW-1:0]     e_idx;
	logic              e_full;
	logic              e_disc;
	logic              e_miss;
	logic [31:0]       e_from;
	logic [31:0]       e_to;
	logic              e_tout;
	logic [31:0]       e_el;
	logic              e_last;
	logic [XW-1:0]     e_idx_ext;

	// Each entry holds {last id, last arrival tick}.
	fsgm_ram #(
		.WIDTH (64),
		.DEPTH (FLOWS)
	) u_flow_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// A freshly inserted flow has last id zero and last tick equal to now.
	assign stored_id = cur_q.fresh ? 32'd0 : rdata[63:32];
	assign stored_t  = cur_q.fresh ? now_q : rdata[31:0];
	assign prev_id   = cur_q.seq_id - 32'd1;
	assign pk_disc   = (stored_id == 32'd0);
	assign eff_id    = pk_disc ? prev_id : stored_id;
	assign pk_miss   = (eff_id != prev_id);
	assign pk_el     = now_q - stored_t;

	assign sc_el  = now_q - rdata[31:0];
	assign sc_hit = vld_s1 && bvalid_q[idx_s1] && (sc_el > timeout_q) &&
	                (found_q < FW'(MAX_REPORTS));

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					case (head.kind)
						JOB_PKT:  state_d = BK_PKT;
						JOB_SCAN: state_d = BK_SCAN;
						default:  state_d = BK_IDLE;
					endcase
				end
			end
			BK_PKT:   state_d = BK_IDLE;
			BK_SCAN: begin
				if (cnt_q == IW'(FLOWS - 1)) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: state_d = BK_FLUSH;
			BK_FLUSH: state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop    = 1'b0;
		raddr  = cnt_q;
		we     = 1'b0;
		waddr  = cur_q.idx[IW-1:0];
		wdata  = {cur_q.seq_id, now_q};
		emit   = 1'b0;
		e_kind = RES_PACKET;
		e_idx  = '0;
		e_full = 1'b0;
		e_disc = 1'b0;
		e_miss = 1'b0;
		e_from = '0;
		e_to   = '0;
		e_tout = 1'b0;
		e_el   = '0;
		e_last = 1'b0;
		case (state_q)
			BK_IDLE: begin
				pop   = !empty;
				raddr = head.idx[IW-1:0];
				if (!empty && (head.kind == JOB_FULL)) begin
					emit   = 1'b1;
					e_full = 1'b1;
					e_last = 1'b1;
				end
			end
			BK_PKT: begin
				we     = 1'b1;
				emit   = 1'b1;
				e_idx  = cur_q.idx[IW-1:0];
				e_disc = pk_disc;
				e_miss = pk_miss;
				e_from = pk_miss ? eff_id + 32'd1 : 32'd0;
				e_to   = pk_miss ? prev_id : 32'd0;
				e_tout = (pk_el > timeout_q);
				e_el   = pk_el;
				e_last = 1'b1;
			end
			BK_SCAN, BK_DRAIN: begin
				// A new hit releases the held one, which is then not the final report.
				if (sc_hit && pend_vld_q) begin
					emit   = 1'b1;
					e_kind = RES_SCAN;
					e_idx  = pend_idx_q;
					e_tout = 1'b1;
					e_el   = pend_el_q;
				end
			end
			BK_FLUSH: begin
				if (pend_vld_q) begin
					emit   = 1'b1;
					e_kind = RES_SCAN;
					e_idx  = pend_idx_q;
					e_tout = 1'b1;
					e_el   = pend_el_q;
					e_last = 1'b1;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign e_idx_ext = XW'(e_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			timeout_q   <= TIMEOUT_RESET;
			now_q       <= '0;
			bvalid_q    <= '0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			pend_vld_q  <= 1'b0;
			found_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= emit;
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			case (state_q)
				BK_IDLE: begin
					if (!empty) begin
						if (head.kind == JOB_TICK) begin
							now_q <= now_q + 32'd1;
						end
						if ((head.kind == JOB_PKT) && head.fresh) begin
							bvalid_q[head.idx[IW-1:0]] <= 1'b1;
						end
						if (head.kind == JOB_SCAN) begin
							cnt_q      <= '0;
							found_q    <= '0;
							pend_vld_q <= 1'b0;
						end
					end
				end
				BK_SCAN: begin
					cnt_q  <= cnt_q + IW'(1);
					vld_s1 <= 1'b1;
				end
				BK_DRAIN: vld_s1 <= 1'b0;
				BK_FLUSH: pend_vld_q <= 1'b0;
				default: vld_s1 <= 1'b0;
			endcase
			if (sc_hit) begin
				found_q    <= found_q + FW'(1);
				pend_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == BK_IDLE) && !empty) begin
			cur_q <= head;
		end
		if (state_q == BK_SCAN) begin
			idx_s1 <= cnt_q;
		end
		if (sc_hit) begin
			pend_idx_q <= idx_s1;
			pend_el_q  <= sc_el;
		end
		kind_q        <= e_kind;
		flow_index_q  <= e_idx_ext[3:0];
		table_full_q  <= e_full;
		discovered_q  <= e_disc;
		missed_q      <= e_miss;
		missed_from_q <= e_from;
		missed_to_q   <= e_to;
		timed_out_q   <= e_tout;
		elapsed_q     <= e_el;
		last_q        <= e_last;
	end

	assign res_valid   = res_valid_q;
	assign kind        = kind_q;
	assign flow_index  = flow_index_q;
	assign table_full  = table_full_q;
	assign discovered  = discovered_q;
	assign missed      = missed_q;
	assign missed_from = missed_from_q;
	assign missed_to   = missed_to_q;
	assign timed_out   = timed_out_q;
	assign elapsed     = elapsed_q;
	assign last        = last_q;

	`FSGM_ASSERT_IMP(a_scan_report_flags, clk, arst_n, res_valid_q && (kind_q == RES_SCAN), timed_out_q && !table_full_q && !discovered_q && !missed_q, "scan report with wrong flags")
	`FSGM_ASSERT_NXT(a_flush_clears_pending, clk, arst_n, state_q == BK_FLUSH, !pend_vld_q, "held scan report survived the flush")
	`FSGM_ASSERT_NXT(a_time_frozen_in_scan, clk, arst_n, state_q == BK_SCAN, $stable(now_q), "tick counter moved during a scan")

endmodule

>>> tb/sv/flow_gap_report_checker.sv
module flow_gap_report_checker import fsgm_pkg::*; #(
	parameter int FLOWS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] src_addr,
	input  logic [15:0] src_port,
	input  logic [31:0] seq_id,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        res_valid,
	input  logic        kind,
	input  logic [3:0]  flow_index,
	input  logic        table_full,
	input  logic        discovered,
	input  logic        missed,
	input  logic [31:0] missed_from,
	input  logic [31:0] missed_to,
	input  logic        timed_out,
	input  logic [31:0] elapsed,
	input  logic        last,
	output int          outstanding,
	output int          failures
);

	typedef struct packed {
		logic        kind;
		logic [3:0]  flow_index;
		logic        table_full;
		logic        discovered;
		logic        missed;
		logic [31:0] missed_from;
		logic [31:0] missed_to;
		logic        timed_out;
		logic [31:0] elapsed;
		logic        last;
	} gap_report_t;

	// Shadow copy of the flow table, the tick counter and the timeout register.
	logic        tbl_valid [FLOWS];
	logic [31:0] tbl_addr [FLOWS];
	logic [15:0] tbl_port [FLOWS];
	logic [31:0] tbl_last_id [FLOWS];
	logic [31:0] tbl_last_tick [FLOWS];
	logic [31:0] tick_count;
	logic [31:0] timeout_limit;

	gap_report_t pending_reports [$];
	int          error_total = 0;

	assign failures = error_total;

	task automatic track_packet(input logic [31:0] addr, input logic [15:0] port,
			input logic [31:0] id);
		int          hit;
		int          vacant;
		logic [31:0] prev;
		gap_report_t r;
		hit = -1;
		vacant = -1;
		for (int i = 0; i < FLOWS; i++) begin
			if (tbl_valid[i]) begin
				if (hit < 0 && tbl_addr[i] == addr && tbl_port[i] == port)
					hit = i;
			end else if (vacant < 0) begin
				vacant = i;
			end
		end
		r = '0;
		r.kind = RES_PACKET;
		r.last = 1'b1;
		if (hit < 0 && vacant < 0) begin
			r.table_full = 1'b1;
			pending_reports.push_back(r);
			return;
		end
		if (hit < 0) begin
			hit = vacant;
			tbl_valid[hit] = 1'b1;
			tbl_addr[hit] = addr;
			tbl_port[hit] = port;
			tbl_last_id[hit] = '0;
			tbl_last_tick[hit] = tick_count;
		end
		prev = id - 32'd1;
		// A stored id of zero always reads as a fresh flow, even for a real id 0.
		if (tbl_last_id[hit] == '0) begin
			tbl_last_id[hit] = prev;
			r.discovered = 1'b1;
		end
		if (tbl_last_id[hit] != prev) begin
			r.missed = 1'b1;
			r.missed_from = tbl_last_id[hit] + 32'd1;
			r.missed_to = prev;
		end
		r.elapsed = tick_count - tbl_last_tick[hit];
		r.timed_out = r.elapsed > timeout_limit;
		r.flow_index = 4'(hit);
		tbl_last_id[hit] = id;
		tbl_last_tick[hit] = tick_count;
		pending_reports.push_back(r);
	endtask

	task automatic sweep_timeouts();
		int          total;
		int          n;
		logic [31:0] el;
		gap_report_t r;
		total = 0;
		n = 0;
		for (int i = 0; i < FLOWS; i++) begin
			el = tick_count - tbl_last_tick[i];
			if (tbl_valid[i] && el > timeout_limit && total < MAX_REPORTS)
				total++;
		end
		for (int i = 0; i < FLOWS; i++) begin
			el = tick_count - tbl_last_tick[i];
			if (tbl_valid[i] && el > timeout_limit && n < total) begin
				r = '0;
				r.kind = RES_SCAN;
				r.flow_index = 4'(i);
				r.timed_out = 1'b1;
				r.elapsed = el;
				r.last = (n == total - 1);
				pending_reports.push_back(r);
				n++;
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			error_total++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		gap_report_t w;
		if (!arst_n) begin
			for (int i = 0; i < FLOWS; i++)
				tbl_valid[i] = 1'b0;
			tick_count = '0;
			timeout_limit = TIMEOUT_RESET;
			pending_reports.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				timeout_limit = cfg_wdata;
			if (res_valid) begin
				if (pending_reports.size() == 0) begin
					error_total++;
					$display("%0t: report with none expected, expected nothing, actual kind %0h index %0h",
						$time, kind, flow_index);
				end else begin
					w = pending_reports.pop_front();
					compare_field("kind", 32'(w.kind), 32'(kind));
					compare_field("flow_index", 32'(w.flow_index), 32'(flow_index));
					compare_field("table_full", 32'(w.table_full), 32'(table_full));
					compare_field("discovered", 32'(w.discovered), 32'(discovered));
					compare_field("missed", 32'(w.missed), 32'(missed));
					compare_field("missed_from", w.missed_from, missed_from);
					compare_field("missed_to", w.missed_to, missed_to);
					compare_field("timed_out", 32'(w.timed_out), 32'(timed_out));
					compare_field("elapsed", w.elapsed, elapsed);
					compare_field("last", 32'(w.last), 32'(last));
				end
			end
			if (start && !busy) begin
				case (opcode)
					OP_PACKET: track_packet(src_addr, src_port, seq_id);
					OP_TICK:   tick_count = tick_count + 32'd1;
					OP_SCAN:   sweep_timeouts();
					default:   ;
				endcase
			end
			outstanding <= pending_reports.size();
		end
	end

endmodule

>>> tb/sv/tb_flow_sequence_gap_monitor_unit.sv
module tb_flow_sequence_gap_monitor_unit;
	import fsgm_pkg::*;

	// The opcode that the block must ignore; the package names only the three live ones.
	localparam logic [1:0] OP_IGNORED = 2'd3;
	// Cycles to wait after the last report before touching the register or ending the run.
	// A scan walks every flow RAM entry in the back end and the job queue can hold two more jobs,
	// so this covers a scan that produces no report at all.
	localparam int TAIL_CYCLES = 64;
	// Cycles without any accepted request or report before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 50;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  opcode = OP_TICK;
	logic [31:0] src_addr = '0;
	logic [15:0] src_port = '0;
	logic [31:0] seq_id = '0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	logic        busy;
	logic        res_valid;
	logic        kind;
	logic [3:0]  flow_index;
	logic        table_full;
	logic        discovered;
	logic        missed;
	logic [31:0] missed_from;
	logic [31:0] missed_to;
	logic        timed_out;
	logic [31:0] elapsed;
	logic        last;

	int outstanding;
	int failures;

	// A fixed set of senders, so that random packets mostly hit flows already
	// in the table and exercise gaps and timeouts rather than the full table.
	logic [31:0] pool_addr [16];
	logic [15:0] pool_port [16];
	logic [31:0] pool_next_id [16];

	// When set, the sender issues requests back to back.
	bit no_gaps = 1'b0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	flow_sequence_gap_monitor_unit #(
		.FLOWS(16)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.src_addr    (src_addr),
		.src_port    (src_port),
		.seq_id      (seq_id),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.res_valid   (res_valid),
		.kind        (kind),
		.flow_index  (flow_index),
		.table_full  (table_full),
		.discovered  (discovered),
		.missed      (missed),
		.missed_from (missed_from),
		.missed_to   (missed_to),
		.timed_out   (timed_out),
		.elapsed     (elapsed),
		.last        (last)
	);

	flow_gap_report_checker #(
		.FLOWS(16)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.src_addr    (src_addr),
		.src_port    (src_port),
		.seq_id      (seq_id),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.res_valid   (res_valid),
		.kind        (kind),
		.flow_index  (flow_index),
		.table_full  (table_full),
		.discovered  (discovered),
		.missed      (missed),
		.missed_from (missed_from),
		.missed_to   (missed_to),
		.timed_out   (timed_out),
		.elapsed     (elapsed),
		.last        (last),
		.outstanding (outstanding),
		.failures    (failures)
	);

	// The watchdog restarts whenever a request is accepted or a report comes out.
	always @(posedge clk) begin
		if ((start && !busy) || res_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Issues one request and returns at the edge that accepts it. Start is left
	// high, so a following request with no gap keeps it high without a glitch;
	// it is lowered only when the next request waits, or when the sender settles.
	task automatic send_request(input logic [1:0] op, input logic [31:0] addr,
			input logic [15:0] port, input logic [31:0] id);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		src_addr <= addr;
		src_port <= port;
		seq_id <= id;
		do @(posedge clk); while (busy);
	endtask

	// Packet from a pooled sender; the next in-order id follows the one sent.
	task automatic send_pooled_packet(input int k, input logic [31:0] id);
		send_request(OP_PACKET, pool_addr[k], pool_port[k], id);
		pool_next_id[k] = id + 32'd1;
	endtask

	// Time ticks and scans carry random payload fields that the block must ignore.
	task automatic send_control(input logic [1:0] op);
		send_request(op, $urandom(), 16'($urandom()), $urandom());
	endtask

	// Holds the sender off until every predicted report has come out. The first
	// edge lets the checker take in a request accepted at the current edge.
	task automatic settle_reports(input bit with_tail);
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		if (with_tail)
			repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// The timeout register is only written once the block has gone quiet.
	task automatic write_timeout(input logic [31:0] value);
		settle_reports(1'b1);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One random request. Packets mostly come from pooled senders with in-order
	// ids, sometimes with a gap, a random id or id zero; a few come from
	// unknown senders and find the table full.
	task automatic send_random_request();
		int sel;
		int k;
		logic [31:0] id;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			if ($urandom_range(0, 99) < 88) begin
				k = $urandom_range(0, 15);
				sel = $urandom_range(0, 99);
				if (sel < 70)
					id = pool_next_id[k];
				else if (sel < 85)
					id = pool_next_id[k] + 32'($urandom_range(1, 6));
				else if (sel < 95)
					id = $urandom();
				else
					id = '0;
				send_pooled_packet(k, id);
			end else begin
				send_request(OP_PACKET, $urandom(), 16'($urandom()), $urandom());
			end
		end else if (sel < 85) begin
			send_control(OP_TICK);
		end else if (sel < 95) begin
			send_control(OP_SCAN);
		end else begin
			send_control(OP_IGNORED);
		end
	endtask

	initial begin
		logic [31:0] phase_timeouts [7];

		pool_addr[0] = '0;
		pool_port[0] = '0;
		pool_addr[1] = '1;
		pool_port[1] = '1;
		for (int k = 2; k < 16; k++) begin
			pool_addr[k] = $urandom();
			pool_port[k] = 16'($urandom());
			pool_next_id[k] = 32'($urandom_range(1, 1000));
		end
		phase_timeouts = '{32'hFFFF_FFFF, 32'd1, 32'd4, 32'd0, 32'd8, 32'd2, $urandom()};

		// Reset is held at the start and then released for good.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the reset timeout of 2000 ticks in force.
		// A new sender sending a genuine id zero is discovered with no gap.
		send_pooled_packet(0, 32'd0);
		// The stored id is now zero again, so the next packet is discovered too.
		send_pooled_packet(0, 32'd1);
		// A forward gap.
		send_pooled_packet(0, 32'd9);
		// Sender with all-ones address and port, starting from the largest id.
		send_pooled_packet(1, 32'hFFFF_FFFF);
		// The id wraps to zero in order.
		send_pooled_packet(1, 32'd0);
		send_pooled_packet(1, 32'd5);
		// A backward jump reports a wrapping missed range.
		send_pooled_packet(1, 32'd3);
		send_control(OP_TICK);
		send_control(OP_TICK);
		send_control(OP_TICK);
		// Three ticks of silence are far below the limit: the scan reports nothing.
		send_control(OP_SCAN);
		send_request(OP_IGNORED, '1, '1, '1);
		send_pooled_packet(0, 32'd10);

		// With a zero timeout any silence at all is a timeout.
		write_timeout(32'd0);
		send_control(OP_SCAN);
		// Fill the remaining table entries, then one more sender finds no room.
		for (int k = 2; k < 16; k++)
			send_pooled_packet(k, pool_next_id[k]);
		send_request(OP_PACKET, $urandom(), 16'($urandom()), $urandom());
		send_control(OP_TICK);
		// Every entry has been silent for a tick: a scan with the full sixteen reports.
		send_control(OP_SCAN);

		// Random part, one phase per timeout setting, the extremes among them.
		foreach (phase_timeouts[p]) begin
			write_timeout(phase_timeouts[p]);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// Switch between back-to-back stretches and random gaps now and then.
				if (n % 16 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
				// Occasionally hold the sender off until the block has answered everything.
				if ($urandom_range(0, 39) == 0)
					settle_reports(1'b0);
				send_random_request();
			end
		end

		// Wait for the last reports, then a little longer for anything stray.
		settle_reports(1'b1);
		if (failures == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
